// ----- rtl/sfad_pkg.sv -----
// Shared types and constants for the sample FIFO with arrival dating.
// No dependencies; the front, back and top files in rtl use this package by scoped names.
package sfad_pkg;

    localparam int SAMPLE_W = 32;
    localparam int STAMP_W  = 48;
    localparam int FUNC_W   = 2;
    localparam int THR_W    = 11;
    localparam int TOTAL_W  = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int S_TDATA_W = SAMPLE_W + STAMP_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Register index as decoded from paddr[2].
    localparam logic REG_NEED_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_TAKE,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic [STAMP_W-1:0]  stamp;
        logic                eof;
    } cmd_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] rec_end;
        logic [STAMP_W-1:0] rec_time;
    } record_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAKE_CHK,
        ST_TAKE_TIME,
        ST_RESP
    } back_state_t;

endpackage

// ----- rtl/sfad_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the sample ring and the record ring.
module sfad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sfad_front.sv -----
// Input side: accepts beats, decodes the function code and queues commands.
// Depends on sfad_pkg.
module sfad_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: sample_in [31:0], arrival_stamp [79:32]
    input  logic [sfad_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: func [1:0]
    input  logic [sfad_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                              s_tlast,
    output logic                              q_valid,
    output sfad_pkg::cmd_t                    q_item,
    input  logic                              q_pop
);

    localparam int QP_W = $clog2(sfad_pkg::QUEUE_DEPTH);
    localparam int QC_W = $clog2(sfad_pkg::QUEUE_DEPTH + 1);

    sfad_pkg::cmd_t   slot_reg [sfad_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  cnt_reg;
    sfad_pkg::cmd_t   cmd;
    logic             push;
    logic             pop;

    always_comb begin
        case (s_tuser)
            sfad_pkg::FUNC_PUSH:  cmd.op = sfad_pkg::OP_PUSH;
            sfad_pkg::FUNC_TAKE:  cmd.op = sfad_pkg::OP_TAKE;
            sfad_pkg::FUNC_CLEAR: cmd.op = sfad_pkg::OP_CLEAR;
            default:              cmd.op = sfad_pkg::OP_NOP;
        endcase
        cmd.sample = s_tdata[sfad_pkg::SAMPLE_W-1:0];
        cmd.stamp  = s_tdata[sfad_pkg::S_TDATA_W-1:sfad_pkg::SAMPLE_W];
        cmd.eof    = s_tlast;
    end

    assign s_tready = (cnt_reg != QC_W'(sfad_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/sfad_back.sv -----
// Execution side: sample ring, record ring, counters and the result register.
// Depends on sfad_pkg and sfad_ram.
module sfad_back #(
    parameter int RING_DEPTH   = 1024,
    parameter int RECORD_DEPTH = 64,
    localparam int FILL_W    = $clog2(RING_DEPTH + 1),
    localparam int OUT_W     = 1 + sfad_pkg::SAMPLE_W + sfad_pkg::STAMP_W + FILL_W + 1,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  sfad_pkg::cmd_t                q_item,
    output logic                          q_pop,
    input  logic [sfad_pkg::THR_W-1:0]    need_threshold,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata
);

    localparam int RP_W = $clog2(RING_DEPTH);
    localparam int RH_W = $clog2(RECORD_DEPTH);
    localparam int RC_W = $clog2(RECORD_DEPTH + 1);
    localparam int TW   = sfad_pkg::TOTAL_W;
    localparam int SW   = sfad_pkg::SAMPLE_W;
    localparam int AW   = sfad_pkg::STAMP_W;

    sfad_pkg::back_state_t state_reg, state_next;
    logic [RP_W-1:0]   rp_reg, rp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [RH_W-1:0]   head_reg, head_next;
    logic [RC_W-1:0]   rcnt_reg, rcnt_next;
    logic [TW-1:0]     total_in_reg, total_in_next;
    logic [TW-1:0]     total_out_reg, total_out_next;
    logic [TW-1:0]     rec_total_reg, rec_total_next;
    logic              res_acc_reg, res_acc_next;
    logic [SW-1:0]     res_sample_reg, res_sample_next;
    logic [AW-1:0]     res_arr_reg, res_arr_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [FILL_W:0]   tail_sum;
    logic [RP_W-1:0]   tail_idx;
    logic [RP_W-1:0]   rp_inc;
    logic [RC_W:0]     rec_sum;
    logic [RH_W-1:0]   rec_slot;
    logic [RH_W-1:0]   head_inc;
    logic              ring_full;
    logic              rec_full;
    logic [TW-1:0]     total_in_inc;
    logic [TW-1:0]     total_out_inc;
    logic [TW-1:0]     diff;
    logic              drop;
    logic [RC_W-1:0]   cnt_after;
    logic              ready_now;
    logic              out_load;

    logic              s_we, s_re;
    logic [SW-1:0]     s_rdata;
    logic              r_we, r_re;
    logic [RH_W-1:0]   r_raddr;
    sfad_pkg::record_t r_wdata, r_rdata;

    sfad_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_sample_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (tail_idx),
        .wdata (q_item.sample),
        .re    (s_re),
        .raddr (rp_reg),
        .rdata (s_rdata)
    );

    sfad_ram #(.WIDTH($bits(sfad_pkg::record_t)), .DEPTH(RECORD_DEPTH)) u_record_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (rec_slot),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    always_comb begin
        tail_sum = (FILL_W + 1)'(rp_reg) + (FILL_W + 1)'(fill_reg);
        if (tail_sum >= (FILL_W + 1)'(RING_DEPTH)) begin
            tail_idx = RP_W'(tail_sum - (FILL_W + 1)'(RING_DEPTH));
        end else begin
            tail_idx = RP_W'(tail_sum);
        end
        rp_inc    = (rp_reg == RP_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        head_inc  = (head_reg == RH_W'(RECORD_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        ring_full = (fill_reg == FILL_W'(RING_DEPTH));
        rec_full  = (rcnt_reg == RC_W'(RECORD_DEPTH));
        rec_sum   = (RC_W + 1)'(head_reg) + (RC_W + 1)'(rcnt_reg);
        if (rec_full) begin
            rec_slot = (head_reg == '0) ? RH_W'(RECORD_DEPTH - 1) : head_reg - 1'b1;
        end else if (rec_sum >= (RC_W + 1)'(RECORD_DEPTH)) begin
            rec_slot = RH_W'(rec_sum - (RC_W + 1)'(RECORD_DEPTH));
        end else begin
            rec_slot = RH_W'(rec_sum);
        end
        total_in_inc  = total_in_reg + 1'b1;
        total_out_inc = total_out_reg + 1'b1;
        diff      = total_out_inc - r_rdata.rec_end;
        drop      = (rcnt_reg != '0) && (diff != '0) && !diff[TW-1];
        cnt_after = drop ? rcnt_reg - 1'b1 : rcnt_reg;
        ready_now = (need_threshold != '0)
                    && (TW'(fill_reg) >= TW'(need_threshold));
        r_wdata.rec_end  = total_in_inc;
        r_wdata.rec_time = q_item.stamp;
    end

    always_comb begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        rcnt_next       = rcnt_reg;
        total_in_next   = total_in_reg;
        total_out_next  = total_out_reg;
        rec_total_next  = rec_total_reg;
        res_acc_next    = res_acc_reg;
        res_sample_next = res_sample_reg;
        res_arr_next    = res_arr_reg;
        q_pop    = 1'b0;
        s_we     = 1'b0;
        s_re     = 1'b0;
        r_we     = 1'b0;
        r_re     = 1'b0;
        r_raddr  = head_reg;
        out_load = 1'b0;

        case (state_reg)
            sfad_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    state_next      = sfad_pkg::ST_RESP;
                    res_acc_next    = 1'b0;
                    res_sample_next = '0;
                    res_arr_next    = '0;
                    case (q_item.op)
                        sfad_pkg::OP_PUSH: begin
                            if (!ring_full) begin
                                s_we          = 1'b1;
                                fill_next     = fill_reg + 1'b1;
                                total_in_next = total_in_inc;
                                res_acc_next  = 1'b1;
                                if (q_item.eof && (total_in_inc != rec_total_reg)) begin
                                    r_we           = 1'b1;
                                    rec_total_next = total_in_inc;
                                    if (!rec_full) begin
                                        rcnt_next = rcnt_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        sfad_pkg::OP_TAKE: begin
                            if (fill_reg != '0) begin
                                s_re       = 1'b1;
                                r_re       = 1'b1;
                                state_next = sfad_pkg::ST_TAKE_CHK;
                            end
                        end
                        sfad_pkg::OP_CLEAR: begin
                            rp_next        = '0;
                            fill_next      = '0;
                            head_next      = '0;
                            rcnt_next      = '0;
                            total_in_next  = '0;
                            total_out_next = '0;
                            rec_total_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sfad_pkg::ST_TAKE_CHK: begin
                res_acc_next    = 1'b1;
                res_sample_next = s_rdata;
                rp_next         = rp_inc;
                fill_next       = fill_reg - 1'b1;
                total_out_next  = total_out_inc;
                state_next      = sfad_pkg::ST_RESP;
                if (drop) begin
                    head_next = head_inc;
                    rcnt_next = cnt_after;
                end
                if (cnt_after != '0) begin
                    if (drop) begin
                        r_re       = 1'b1;
                        r_raddr    = head_inc;
                        state_next = sfad_pkg::ST_TAKE_TIME;
                    end else begin
                        res_arr_next = r_rdata.rec_time;
                    end
                end
            end
            sfad_pkg::ST_TAKE_TIME: begin
                res_arr_next = r_rdata.rec_time;
                state_next   = sfad_pkg::ST_RESP;
            end
            sfad_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = sfad_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tdata_next = m_tdata_reg;
        if (out_load) begin
            m_tdata_next = '0;
            m_tdata_next[OUT_W-1:0] = {ready_now, fill_reg, res_arr_reg,
                                       res_sample_reg, res_acc_reg};
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sfad_pkg::ST_IDLE;
            rp_reg        <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            rcnt_reg      <= '0;
            total_in_reg  <= '0;
            total_out_reg <= '0;
            rec_total_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            rcnt_reg      <= rcnt_next;
            total_in_reg  <= total_in_next;
            total_out_reg <= total_out_next;
            rec_total_reg <= rec_total_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_acc_reg    <= res_acc_next;
        res_sample_reg <= res_sample_next;
        res_arr_reg    <= res_arr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/sample_fifo_with_arrival_dating_top.sv -----
// Channel   Direction  Payload
// s_        in         tdata: sample_in, arrival_stamp; tuser: func; tlast: end_of_frame
// m_        out        tdata: accepted, sample_out, arrival_time, fill_level, ready_res
// APB       in/out     register 0 at byte address 0: need_threshold
// A push, clear, no-op or take from an empty ring goes from idle straight to the result state in the
// execution side; a take passes through a check state first, and a time state as well when it retires
// a record and another record remains, since each ring is read through a registered port.
// A two-beat command queue lets the input side keep accepting while a result is held.
// Reset is synchronous and active low; the ring memories are not cleared and need no pass.
// Top level: configuration register, input side and execution side.
// Depends on sfad_pkg, sfad_front and sfad_back.
module sample_fifo_with_arrival_dating_top #(
    parameter int RING_DEPTH   = 1024,
    parameter int RECORD_DEPTH = 64,
    localparam int FILL_W    = $clog2(RING_DEPTH + 1),
    localparam int OUT_W     = 1 + sfad_pkg::SAMPLE_W + sfad_pkg::STAMP_W + FILL_W + 1,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: sample_in [31:0], arrival_stamp [79:32]
    input  logic [sfad_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: func [1:0]
    input  logic [sfad_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: accepted [0], sample_out [32:1], arrival_time [80:33],
    // fill_level [81+FILL_W-1:81], ready_res [81+FILL_W], zero fill above
    output logic [M_TDATA_W-1:0]              m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfad_pkg::PADDR_W-1:0]      paddr,
    input  logic [sfad_pkg::PDATA_W-1:0]      pwdata,
    output logic [sfad_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [sfad_pkg::THR_W-1:0] thr_reg;
    logic                       cfg_wr;
    logic                       q_valid;
    logic                       q_pop;
    sfad_pkg::cmd_t             q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == sfad_pkg::REG_NEED_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr) begin
            thr_reg <= pwdata[sfad_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == sfad_pkg::REG_NEED_THRESHOLD) begin
            prdata = sfad_pkg::PDATA_W'(thr_reg);
        end else begin
            prdata = '0;
        end
    end

    sfad_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sfad_back #(
        .RING_DEPTH   (RING_DEPTH),
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .need_threshold (thr_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// ----- dv/sample_fifo_with_arrival_dating_top_tb.sv -----
// Self-checking testbench for sample_fifo_with_arrival_dating_top: predicts every result beat
// and compares it field by field under random idling and stalls on both stream channels.
// Depends on sfad_pkg and the RTL top level; needs no files or arguments.
`timescale 1ns / 1ps

module sample_fifo_with_arrival_dating_top_tb;

    localparam int RING = 1024;
    localparam int RECS = 64;
    localparam int RING_AW = $clog2(RING);
    localparam int RECS_AW = $clog2(RECS);
    localparam int FILL_BITS = $clog2(RING + 1);
    localparam int OUT_BITS = 1 + sfad_pkg::SAMPLE_W + sfad_pkg::STAMP_W + FILL_BITS + 1;
    localparam int M_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int LIMIT = 1000000;
    localparam logic [sfad_pkg::PADDR_W-1:0] THR_ADDR = {sfad_pkg::REG_NEED_THRESHOLD, 2'b00};
    localparam logic [sfad_pkg::STAMP_W-1:0] STAMP_MAX = '1;

    class arrival_dating_board;
        typedef struct packed {
            logic                          accepted;
            logic [sfad_pkg::SAMPLE_W-1:0] sample;
            logic [sfad_pkg::STAMP_W-1:0]  arrival;
            logic [FILL_BITS-1:0]          fill;
            logic                          ready;
        } reply_t;

        reply_t pending_replies[$];
        logic [sfad_pkg::SAMPLE_W-1:0] ring [RING];
        logic [sfad_pkg::TOTAL_W-1:0] frame_end [RECS];
        logic [sfad_pkg::STAMP_W-1:0] frame_time [RECS];
        int unsigned rd_ptr, fill, rec_head, rec_count;
        logic [sfad_pkg::TOTAL_W-1:0] pushed, taken, dated;
        logic [sfad_pkg::THR_W-1:0] threshold;
        int mismatches;

        function new();
            threshold = '0;
            mismatches = 0;
            empty_queue();
        endfunction

        function void empty_queue();
            rd_ptr = 0;
            fill = 0;
            rec_head = 0;
            rec_count = 0;
            pushed = '0;
            taken = '0;
            dated = '0;
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch in %s: expected %h, got %h", field, want, got);
            end
        endfunction

        function void log_command(sfad_pkg::op_t op, logic [sfad_pkg::SAMPLE_W-1:0] word,
                                  logic [sfad_pkg::STAMP_W-1:0] stamp, logic eof);
            reply_t reply;
            int unsigned slot;
            logic [sfad_pkg::TOTAL_W-1:0] diff;
            reply = '0;
            case (op)
                sfad_pkg::OP_PUSH: begin
                    if (fill < RING) begin
                        ring[RING_AW'((rd_ptr + fill) % RING)] = word;
                        fill++;
                        pushed++;
                        reply.accepted = 1'b1;
                        if (eof && pushed != dated) begin
                            if (rec_count >= RECS) begin
                                slot = (rec_head + RECS - 1) % RECS;
                            end else begin
                                slot = (rec_head + rec_count) % RECS;
                                rec_count++;
                            end
                            frame_end[RECS_AW'(slot)] = pushed;
                            frame_time[RECS_AW'(slot)] = stamp;
                            dated = pushed;
                        end
                    end
                end
                sfad_pkg::OP_TAKE: begin
                    if (fill > 0) begin
                        reply.sample = ring[RING_AW'(rd_ptr)];
                        rd_ptr = (rd_ptr + 1) % RING;
                        fill--;
                        taken++;
                        reply.accepted = 1'b1;
                        if (rec_count > 0) begin
                            diff = taken - frame_end[RECS_AW'(rec_head)];
                            if (diff != 0 && !diff[sfad_pkg::TOTAL_W-1]) begin
                                rec_head = (rec_head + 1) % RECS;
                                rec_count--;
                            end
                        end
                        if (rec_count > 0)
                            reply.arrival = frame_time[RECS_AW'(rec_head)];
                    end
                end
                sfad_pkg::OP_CLEAR: empty_queue();
                default: ;
            endcase
            reply.fill = FILL_BITS'(fill);
            reply.ready = (threshold != 0) && (fill >= threshold);
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic [M_W-1:0] data);
            reply_t want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result beat with no expectation waiting: %h", data);
                return;
            end
            want = pending_replies.pop_front();
            compare("accepted", 64'(want.accepted), 64'(data[0]));
            compare("sample_out", 64'(want.sample), 64'(data[1 +: sfad_pkg::SAMPLE_W]));
            compare("arrival_time", 64'(want.arrival),
                    64'(data[1 + sfad_pkg::SAMPLE_W +: sfad_pkg::STAMP_W]));
            compare("fill_level", 64'(want.fill),
                    64'(data[1 + sfad_pkg::SAMPLE_W + sfad_pkg::STAMP_W +: FILL_BITS]));
            compare("ready_res", 64'(want.ready), 64'(data[OUT_BITS-1]));
            compare("m_tdata padding", 64'(0), 64'(data[M_W-1:OUT_BITS]));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sfad_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [sfad_pkg::FUNC_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sfad_pkg::PADDR_W-1:0] paddr = '0;
    logic [sfad_pkg::PDATA_W-1:0] pwdata = '0;
    logic [sfad_pkg::PDATA_W-1:0] prdata;
    logic pready;

    arrival_dating_board board = new();
    int cycles = 0;
    int sent = 0;
    int frame_left = 0;
    bit s_steady = 1'b0;
    bit m_steady = 1'b0;

    sample_fifo_with_arrival_dating_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_reply(m_tdata);
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [sfad_pkg::STAMP_W-1:0] rand_stamp();
        return sfad_pkg::STAMP_W'({$urandom, $urandom});
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < 2)
                m_steady = !m_steady;
            stall = m_steady ? 0 : idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_command(input sfad_pkg::op_t op,
                                input logic [sfad_pkg::SAMPLE_W-1:0] word,
                                input logic [sfad_pkg::STAMP_W-1:0] stamp, input logic eof);
        int gap;
        sent++;
        if (sent % 64 == 0)
            s_steady = ($urandom_range(0, 3) == 0);
        gap = s_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, word};
        s_tuser <= op;
        s_tlast <= eof;
        do @(posedge aclk); while (!s_tready);
        board.log_command(op, word, stamp, eof);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [sfad_pkg::THR_W-1:0] level);
        logic [sfad_pkg::PDATA_W-1:0] readback;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THR_ADDR;
        pwdata <= sfad_pkg::PDATA_W'(level);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.threshold = level;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        board.compare("need_threshold readback", 64'(level), 64'(readback));
    endtask

    task automatic push_framed();
        logic eof;
        if (frame_left == 0)
            frame_left = $urandom_range(1, 12);
        frame_left--;
        eof = (frame_left == 0);
        if ($urandom_range(0, 19) == 0)
            eof = rand_bit();
        send_command(sfad_pkg::OP_PUSH, $urandom, rand_stamp(), eof);
    endtask

    task automatic run_mix(input int count, input int push_pct, input int take_pct);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                push_framed();
            else if (pick < push_pct + take_pct)
                send_command(sfad_pkg::OP_TAKE, $urandom, rand_stamp(), rand_bit());
            else if (pick < 98)
                send_command(sfad_pkg::OP_NOP, $urandom, rand_stamp(), rand_bit());
            else
                send_command(sfad_pkg::OP_CLEAR, $urandom, rand_stamp(), rand_bit());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset threshold of zero: ready must stay low throughout.
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_NOP, 32'hFFFF_FFFF, STAMP_MAX, 1'b1);
        send_command(sfad_pkg::OP_PUSH, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_PUSH, 32'hFFFF_FFFF, STAMP_MAX, 1'b1);
        send_command(sfad_pkg::OP_PUSH, 32'hA5A5_A5A5, 48'h1, 1'b1);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b1);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_PUSH, 32'h5A5A_5A5A, 48'h8000_0000_0000, 1'b0);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_PUSH, 32'h1234_5678, 48'h1234_5678_9ABC, 1'b1);
        send_command(sfad_pkg::OP_PUSH, 32'h8000_0001, 48'h7FFF_FFFF_FFFF, 1'b1);
        send_command(sfad_pkg::OP_NOP, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_CLEAR, 32'hFFFF_FFFF, STAMP_MAX, 1'b1);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_PUSH, 32'hDEAD_BEEF, 48'hABCD_EF01_2345, 1'b1);
        send_command(sfad_pkg::OP_PUSH, 32'h0F0F_0F0F, 48'h5555_5555_5555, 1'b1);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b1);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        send_command(sfad_pkg::OP_TAKE, 32'h0, 48'h0, 1'b0);
        wait_idle();

        set_threshold(11'd1);
        run_mix(200, 50, 42);
        wait_idle();

        // Fill the ring to the top, overflowing the record ring on the way.
        set_threshold(11'd1024);
        while (board.fill < RING) begin
            if ($urandom_range(0, 15) == 0)
                send_command(sfad_pkg::OP_TAKE, $urandom, rand_stamp(), 1'b0);
            else
                push_framed();
        end
        repeat (6) send_command(sfad_pkg::OP_PUSH, $urandom, rand_stamp(), 1'b1);
        run_mix(40, 30, 66);
        send_command(sfad_pkg::OP_CLEAR, $urandom, rand_stamp(), 1'b0);
        wait_idle();

        set_threshold(sfad_pkg::THR_W'($urandom_range(2, 1022)));
        run_mix(200, 58, 34);
        wait_idle();

        set_threshold(11'd1023);
        run_mix(150, 40, 52);
        wait_idle();

        set_threshold(11'd0);
        run_mix(150, 50, 42);
        wait_idle();

        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
